// File: rtl/pwdb_pkg.sv
// Package for the PID step controller with deadband.
// Holds field widths, reset values, register indexes and the command and
// status structures shared by the controller, the datapath and the top level.
package pwdb_pkg;

  localparam int ANGLE_W        = 32;
  localparam int STEP_W         = 16;
  localparam int ERR_W          = ANGLE_W + 1;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int GAIN_W         = 32;
  localparam int ACC_W          = 32;
  localparam int LIM_W          = 31;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int MUL_A_W        = 32;
  localparam int MUL_B_W        = ERR_W;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam int DIV_W          = DIFF_W + STEP_W;
  localparam int DIV_CNT_W      = $clog2(DIV_W);
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [GAIN_W-1:0] KP_RST     = 32'd3735552;
  localparam logic [GAIN_W-1:0] KI_RST     = 32'd0;
  localparam logic [GAIN_W-1:0] KD_RST     = 32'd65536;
  localparam logic [GAIN_W-1:0] TARGET_RST = 32'd65536;
  localparam logic [LIM_W-1:0]  DBAND_RST  = 31'd1311;
  localparam logic [LIM_W-1:0]  ILIM_RST   = 31'd3276800;
  localparam logic [LIM_W-1:0]  OLIM_RST   = 31'd65536000;

  localparam logic [ACC_W-1:0] DERIV_MAX = 32'h7FFF_FFFF;
  localparam logic [ACC_W-1:0] DERIV_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_TARGET = 3'd3,
    CFG_DBAND  = 3'd4,
    CFG_ILIM   = 3'd5,
    CFG_OLIM   = 3'd6
  } pwdb_cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] target;
    logic [LIM_W-1:0]  dband;
    logic [LIM_W-1:0]  ilim;
    logic [LIM_W-1:0]  olim;
  } pwdb_cfg_t;

  localparam pwdb_cfg_t CFG_RESET = '{
    kp:     KP_RST,
    ki:     KI_RST,
    kd:     KD_RST,
    target: TARGET_RST,
    dband:  DBAND_RST,
    ilim:   ILIM_RST,
    olim:   OLIM_RST
  };

  typedef enum logic [1:0] {
    MUL_STEP = 2'd0,
    MUL_KP   = 2'd1,
    MUL_KI   = 2'd2,
    MUL_KD   = 2'd3
  } pwdb_mul_sel_t;

  typedef struct packed {
    logic          load;
    logic          calc_err;
    logic          mul_en;
    pwdb_mul_sel_t mul_sel;
    logic          integ;
    logic          div_start;
    logic          sum_init;
    logic          sum_add;
    logic          deriv;
    logic          zero_out;
    logic          finish;
  } pwdb_cmd_t;

  typedef struct packed {
    logic in_deadband;
    logic div_busy;
    logic out_free;
  } pwdb_status_t;

endpackage

// File: rtl/pwdb_in_if.sv
// Request channel carrying one angle sample and its time step.
// Depends on pwdb_pkg for the field widths.
interface pwdb_in_if;
  import pwdb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_sample;
  logic        [STEP_W-1:0]  time_step;

  modport source (output valid, output angle_sample, output time_step, input ready);
  modport sink   (input valid, input angle_sample, input time_step, output ready);
endinterface

// File: rtl/pwdb_out_if.sv
// Result channel carrying the drive value and its two flags.
// Depends on pwdb_pkg for the field widths.
interface pwdb_out_if;
  import pwdb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] drive_value;
  logic                      deadband_hit;
  logic                      drive_clamped;

  modport source (output valid, output drive_value, output deadband_hit,
                  output drive_clamped, input ready);
  modport sink   (input valid, input drive_value, input deadband_hit,
                  input drive_clamped, output ready);
endinterface

// File: rtl/pid_with_deadband_step_core.sv
// PID step controller with deadband: one angle sample and time step in,
// one clamped drive value with deadband and clamp flags out.
// The request channel in_chan takes a signed Q16.16 angle and an unsigned Q0.16
// step; a zero step counts as the smallest step. The result channel out_chan
// returns the drive value and its flags, one result for every request.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the block is idle, as the block does not enforce
// this; an index beyond the last register is ignored.
// A request inside the deadband puts its result on out_chan and clears the
// integrator and the stored error. Any other request runs the one-bit-per-cycle
// divider that forms the derivative, and the error-times-step product and the
// three gain products share one 32 by 33 bit multiplier. One request is
// processed at a time and the next can be taken in the cycle the result appears.
// The result sits in an output register: a new request is accepted while an
// earlier result still waits, and a stalled receiver holds the block only when
// the next result is ready to be written.
// Synchronous reset returns the registers to their defaults, clears the
// integrator and the stored error, and empties the output register.
module pid_with_deadband_step_core #(
  parameter int FRAC_BITS = pwdb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pwdb_in_if.sink                          in_chan,
  pwdb_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [pwdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwdb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pwdb_pkg::*;

  pwdb_cfg_t          cfg;
  pwdb_cmd_t          cmd;
  pwdb_status_t       status;
  logic               in_ready;
  logic               out_valid;
  logic [ANGLE_W-1:0] out_drive;
  logic               out_deadband;
  logic               out_clamped;

  pwdb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pwdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pwdb_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg),
    .in_angle     (in_chan.angle_sample),
    .in_step      (in_chan.time_step),
    .out_ready    (out_chan.ready),
    .out_valid    (out_valid),
    .out_drive    (out_drive),
    .out_deadband (out_deadband),
    .out_clamped  (out_clamped)
  );

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid;
  assign out_chan.drive_value   = out_drive;
  assign out_chan.deadband_hit  = out_deadband;
  assign out_chan.drive_clamped = out_clamped;

  a_deadband_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.deadband_hit |->
      out_chan.drive_value == '0 && !out_chan.drive_clamped)
    else $error("deadband result carries a non-zero drive or a clamp flag");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second request accepted while one is in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && in_chan.ready)
    else $error("block not idle and empty after reset");

endmodule

// File: rtl/pwdb_cfg.sv
// Configuration register bank for the PID step controller.
// Depends on pwdb_pkg for the register indexes and reset values.
module pwdb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pwdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwdb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pwdb_pkg::pwdb_cfg_t              cfg
);
  import pwdb_pkg::*;

  pwdb_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (pwdb_cfg_idx_t'(cfg_index))
        CFG_KP:     cfg_r.kp     <= cfg_wdata[GAIN_W-1:0];
        CFG_KI:     cfg_r.ki     <= cfg_wdata[GAIN_W-1:0];
        CFG_KD:     cfg_r.kd     <= cfg_wdata[GAIN_W-1:0];
        CFG_TARGET: cfg_r.target <= cfg_wdata[GAIN_W-1:0];
        CFG_DBAND:  cfg_r.dband  <= cfg_wdata[LIM_W-1:0];
        CFG_ILIM:   cfg_r.ilim   <= cfg_wdata[LIM_W-1:0];
        CFG_OLIM:   cfg_r.olim   <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/pwdb_div.sv
// Restoring divider, one quotient bit per cycle, for the derivative term.
// Depends on pwdb_pkg for the dividend and divisor widths.
module pwdb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pwdb_pkg::DIV_W-1:0]    dividend,
  input  logic [pwdb_pkg::STEP_W-1:0]   divisor,
  output logic                          busy,
  output logic [pwdb_pkg::DIV_W-1:0]    quotient
);
  import pwdb_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dq_r;
  logic [STEP_W-1:0]    rem_r;
  logic [STEP_W-1:0]    dvs_r;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      trial_sub;
  logic                 q_bit;
  logic [STEP_W-1:0]    rem_nxt;

  assign trial     = {rem_r, dq_r[DIV_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign q_bit     = ~trial_sub[STEP_W];
  assign rem_nxt   = q_bit ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DIV_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

// File: rtl/pwdb_dp.sv
// Datapath of the PID step controller: error, integrator, derivative,
// shared multiplier, sum and output register. Depends on pwdb_pkg and pwdb_div.
module pwdb_dp #(
  parameter int FRAC_BITS = pwdb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pwdb_pkg::pwdb_cmd_t              cmd,
  output pwdb_pkg::pwdb_status_t           status,
  input  pwdb_pkg::pwdb_cfg_t              cfg,
  input  logic [pwdb_pkg::ANGLE_W-1:0]     in_angle,
  input  logic [pwdb_pkg::STEP_W-1:0]      in_step,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [pwdb_pkg::ANGLE_W-1:0]     out_drive,
  output logic                             out_deadband,
  output logic                             out_clamped
);
  import pwdb_pkg::*;

  localparam int TERM_MAG_W = PROD_W - FRAC_BITS;
  localparam int TERM_W     = TERM_MAG_W + 1;
  localparam int SUM_W      = TERM_W + 2;
  localparam int ACC_SUM_W  = ERR_W + 1;

  function automatic logic [MUL_A_W-1:0] abs32(input logic [MUL_A_W-1:0] v);
    return v[MUL_A_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [ANGLE_W-1:0] angle_r;
  logic [STEP_W-1:0]  dt_r;
  logic [ERR_W-1:0]   err_r;
  logic [ERR_W-1:0]   last_r;
  logic [ACC_W-1:0]   acc_r;
  logic [PROD_W-1:0]  prod_r;
  logic               prod_neg_r;
  logic [SUM_W-1:0]   sum_r;
  logic               dneg_r;
  logic [ACC_W-1:0]   deriv_r;
  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_drive_r;
  logic               out_deadband_r;
  logic               out_clamped_r;

  logic [ERR_W-1:0]     err_abs;
  logic                 in_db;
  logic [ERR_W-1:0]     step_mag;
  logic [ACC_SUM_W-1:0] step_term;
  logic [ACC_SUM_W-1:0] acc_sum;
  logic [ACC_SUM_W-1:0] ilim_ext;
  logic [ACC_SUM_W-1:0] ilim_neg;
  logic [ACC_W-1:0]     acc_nxt;
  logic [DIFF_W-1:0]    diff;
  logic [DIFF_W-1:0]    diff_abs;
  logic [DIV_W-1:0]     quot;
  logic                 div_busy;
  logic                 q_hi_nz;
  logic [ACC_W-1:0]     deriv_nxt;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic                 mul_neg;
  logic [TERM_MAG_W-1:0] term_mag;
  logic [TERM_W-1:0]    term_s;
  logic [SUM_W-1:0]     term_ext;
  logic [SUM_W-1:0]     olim_ext;
  logic [SUM_W-1:0]     olim_neg;
  logic                 clamp_hi;
  logic                 clamp_lo;
  logic [ANGLE_W-1:0]   drive_nxt;

  assign err_abs = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
  assign in_db   = err_abs < {{(ERR_W-LIM_W){1'b0}}, cfg.dband};

  // Integrator update with the error-times-step product, clamped to the ilim bound.
  assign step_mag  = prod_r[STEP_W +: ERR_W];
  assign step_term = prod_neg_r ? (~{1'b0, step_mag} + 1'b1) : {1'b0, step_mag};
  assign acc_sum   = {{(ACC_SUM_W-ACC_W){acc_r[ACC_W-1]}}, acc_r} + step_term;
  assign ilim_ext  = {{(ACC_SUM_W-LIM_W){1'b0}}, cfg.ilim};
  assign ilim_neg  = ~ilim_ext + 1'b1;

  always_comb begin
    if ($signed(acc_sum) > $signed(ilim_ext)) begin
      acc_nxt = ilim_ext[ACC_W-1:0];
    end else if ($signed(acc_sum) < $signed(ilim_neg)) begin
      acc_nxt = ilim_neg[ACC_W-1:0];
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  // Derivative: magnitude of the error change over the step, then sign and saturation.
  assign diff     = {err_r[ERR_W-1], err_r} - {last_r[ERR_W-1], last_r};
  assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

  pwdb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({diff_abs, {STEP_W{1'b0}}}),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign q_hi_nz = |quot[DIV_W-1:ACC_W];

  always_comb begin
    if (dneg_r) begin
      if (q_hi_nz || (quot[ACC_W-1] && (|quot[ACC_W-2:0]))) begin
        deriv_nxt = DERIV_MIN;
      end else begin
        deriv_nxt = ~quot[ACC_W-1:0] + 1'b1;
      end
    end else begin
      if (q_hi_nz || quot[ACC_W-1]) begin
        deriv_nxt = DERIV_MAX;
      end else begin
        deriv_nxt = quot[ACC_W-1:0];
      end
    end
  end

  // Operand selection for the shared sign-magnitude multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_STEP: begin
        mul_a   = {{(MUL_A_W-STEP_W){1'b0}}, dt_r};
        mul_b   = err_abs;
        mul_neg = err_r[ERR_W-1];
      end
      MUL_KP: begin
        mul_a   = abs32(cfg.kp);
        mul_b   = err_abs;
        mul_neg = cfg.kp[GAIN_W-1] ^ err_r[ERR_W-1];
      end
      MUL_KI: begin
        mul_a   = abs32(cfg.ki);
        mul_b   = {1'b0, abs32(acc_r)};
        mul_neg = cfg.ki[GAIN_W-1] ^ acc_r[ACC_W-1];
      end
      MUL_KD: begin
        mul_a   = abs32(cfg.kd);
        mul_b   = {1'b0, abs32(deriv_r)};
        mul_neg = cfg.kd[GAIN_W-1] ^ deriv_r[ACC_W-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // Gained term: the product scaled back by the fraction bits.
  assign term_mag = prod_r[PROD_W-1:FRAC_BITS];
  assign term_s   = prod_neg_r ? (~{1'b0, term_mag} + 1'b1) : {1'b0, term_mag};
  assign term_ext = {{(SUM_W-TERM_W){term_s[TERM_W-1]}}, term_s};

  assign olim_ext  = {{(SUM_W-LIM_W){1'b0}}, cfg.olim};
  assign olim_neg  = ~olim_ext + 1'b1;
  assign clamp_hi  = $signed(sum_r) > $signed(olim_ext);
  assign clamp_lo  = $signed(sum_r) < $signed(olim_neg);
  assign drive_nxt = clamp_hi ? olim_ext[ANGLE_W-1:0] :
                     clamp_lo ? olim_neg[ANGLE_W-1:0] : sum_r[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= in_angle;
      dt_r    <= (in_step == '0) ? STEP_W'(1) : in_step;
    end
    if (cmd.calc_err) begin
      err_r <= {angle_r[ANGLE_W-1], angle_r} - {cfg.target[GAIN_W-1], cfg.target};
    end
    if (cmd.mul_en) begin
      prod_r     <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
      prod_neg_r <= mul_neg;
    end
    if (cmd.sum_init) begin
      sum_r <= term_ext;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + term_ext;
    end
    if (cmd.div_start) begin
      dneg_r <= diff[DIFF_W-1];
    end
    if (cmd.deriv) begin
      deriv_r <= deriv_nxt;
    end
    if (cmd.zero_out) begin
      out_drive_r    <= '0;
      out_deadband_r <= 1'b1;
      out_clamped_r  <= 1'b0;
    end else if (cmd.finish) begin
      out_drive_r    <= drive_nxt;
      out_deadband_r <= 1'b0;
      out_clamped_r  <= clamp_hi | clamp_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.zero_out) begin
        acc_r  <= '0;
        last_r <= '0;
      end else begin
        if (cmd.integ) begin
          acc_r <= acc_nxt;
        end
        if (cmd.finish) begin
          last_r <= err_r;
        end
      end
      if (cmd.zero_out || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.in_deadband = in_db;
  assign status.div_busy    = div_busy;
  assign status.out_free    = ~out_valid_r | out_ready;

  assign out_valid    = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_deadband = out_deadband_r;
  assign out_clamped  = out_clamped_r;

endmodule

// File: rtl/pwdb_ctrl.sv
// Sequencer of the PID step controller: steps the datapath through one request.
// Depends on pwdb_pkg for the command and status structures.
module pwdb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pwdb_pkg::pwdb_status_t  status,
  output pwdb_pkg::pwdb_cmd_t     cmd
);
  import pwdb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ERR   = 12'b0000_0000_0010,
    S_CHECK = 12'b0000_0000_0100,
    S_ZERO  = 12'b0000_0000_1000,
    S_INTEG = 12'b0000_0001_0000,
    S_PADD  = 12'b0000_0010_0000,
    S_IADD  = 12'b0000_0100_0000,
    S_DWAIT = 12'b0000_1000_0000,
    S_DERIV = 12'b0001_0000_0000,
    S_MULD  = 12'b0010_0000_0000,
    S_DADD  = 12'b0100_0000_0000,
    S_CLAMP = 12'b1000_0000_0000
  } pwdb_state_t;

  pwdb_state_t state_r;
  pwdb_state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (status.in_deadband) begin
          state_nxt = S_ZERO;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_STEP;
          state_nxt   = S_INTEG;
        end
      end
      S_ZERO: begin
        if (status.out_free) begin
          cmd.zero_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_INTEG: begin
        cmd.integ     = 1'b1;
        cmd.div_start = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_KP;
        state_nxt     = S_PADD;
      end
      S_PADD: begin
        cmd.sum_init = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_KI;
        state_nxt    = S_IADD;
      end
      S_IADD: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_DWAIT;
      end
      S_DWAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_DERIV;
        end
      end
      S_DERIV: begin
        cmd.deriv = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KD;
        state_nxt   = S_DADD;
      end
      S_DADD: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_CLAMP;
      end
      S_CLAMP: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
